FILE: src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: src/brc_pkg.sv
// Package with shared types, constants and arithmetic helpers for the compensator.
`default_nettype none
package brc_pkg;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned DivW = 32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = 2;
  // Tag carried alongside each divide; wide enough for the temperature half's tag.
  localparam int unsigned DivTagW = 50;

  typedef enum logic [RegIdxW-1:0] {
    REG_AC1 = 3'd0, REG_AC2 = 3'd1, REG_AC3 = 3'd2, REG_AC4 = 3'd3,
    REG_AC5 = 3'd4, REG_AC6 = 3'd5, REG_B1B2 = 3'd6, REG_MCMD = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6;
    logic [31:0] b1b2, mcmd;
  } coef_t;

  // Item handed from the front part to the back part through the queue.
  typedef struct packed {
    logic [31:0] b5;
    logic [15:0] up;
    logic        fault;
  } mid_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
    asr = 32'($signed(v) >>> s);
  endfunction
endpackage
`default_nettype wire

FILE: src/brc_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned 32 by 32.
`default_nettype none
module brc_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_vld,
  input  wire logic [31:0]                 in_num,
  input  wire logic [31:0]                 in_den,
  input  wire logic [brc_pkg::DivTagW-1:0] in_tag,
  output logic                             out_vld,
  output logic [31:0]                      out_quo,
  output logic [brc_pkg::DivTagW-1:0]      out_tag
);
  localparam int unsigned N = brc_pkg::DivW;
  logic [N:0]                  vld;
  logic [31:0]                 rem [N+1];
  logic [31:0]                 quo [N+1];
  logic [31:0]                 den [N+1];
  logic [brc_pkg::DivTagW-1:0] tag [N+1];

  always_comb begin
    vld[0] = in_vld;
    rem[0] = '0;
    quo[0] = in_num;
    den[0] = in_den;
    tag[0] = in_tag;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [32:0] sh;
    logic [32:0] diff;
    assign sh   = {rem[i], quo[i][31]};
    assign diff = sh - {1'b0, den[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1] <= diff[32] ? sh[31:0] : diff[31:0];
        quo[i+1] <= {quo[i][30:0], ~diff[32]};
        den[i+1] <= den[i];
        tag[i+1] <= tag[i];
      end
    end
  end

  assign out_vld = vld[N];
  assign out_quo = quo[N];
  assign out_tag = tag[N];
endmodule
`default_nettype wire

FILE: src/brc_front.sv
// Temperature half: accepts readings, computes B5 and the temperature fault.
`default_nettype none
module brc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire brc_pkg::coef_t coef,
  input  wire logic           in_vld,
  input  wire logic [15:0]    ut,
  input  wire logic [15:0]    up,
  output logic                out_vld,
  output brc_pkg::mid_t       out_item
);
  typedef struct packed {
    logic [31:0] x1;
    logic        neg;
    logic [15:0] up;
    logic        fault;
  } ftag_t;

  logic        s1_vld;
  logic [31:0] s1_prod;
  logic [15:0] s1_up;
  logic [31:0] x1;
  logic [31:0] d;
  logic [31:0] num;
  logic        neg;
  ftag_t       tin, tout;
  logic        dv;
  logic [31:0] q;
  logic [31:0] x2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_vld;
    end
    if (en) begin
      s1_prod <= 32'((ut - coef.ac6) * coef.ac5);
      s1_up   <= up;
    end
  end

  always_comb begin
    x1  = brc_pkg::asr(s1_prod, 15);
    d   = x1 + brc_pkg::sext16(coef.mcmd[15:0]);
    num = {{5{coef.mcmd[31]}}, coef.mcmd[31:16], 11'd0};
    neg = num[31] ^ d[31];
    tin = '{x1: x1, neg: neg, up: s1_up, fault: (d == '0)};
  end

  brc_div u_div (
    .clk, .rst, .en,
    .in_vld (s1_vld),
    .in_num (num[31] ? -num : num),
    .in_den (d[31] ? -d : d),
    .in_tag (tin),
    .out_vld(dv),
    .out_quo(q),
    .out_tag(tout)
  );

  assign x2 = tout.neg ? -q : q;
  assign out_vld = dv;
  assign out_item = '{b5: tout.x1 + x2, up: tout.up, fault: tout.fault};
endmodule
`default_nettype wire

FILE: src/brc_queue.sv
// Short FIFO between the temperature and pressure halves.
`default_nettype none
module brc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire brc_pkg::mid_t wdata,
  input  wire logic          rd,
  output logic               nonempty,
  output logic [brc_pkg::QueuePtrW:0] count,
  output brc_pkg::mid_t      rdata
);
  brc_pkg::mid_t mem [brc_pkg::QueueDepth];
  logic [brc_pkg::QueuePtrW-1:0] wp, rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
    end
    if (wr) mem[wp] <= wdata;
  end

  assign nonempty = count != '0;
  assign rdata = mem[rp];
endmodule
`default_nettype wire

FILE: src/brc_back.sv
// Pressure half: B3, B4, B7 divide, final correction and saturation.
`default_nettype none
module brc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire brc_pkg::coef_t coef,
  input  wire logic           in_vld,
  input  wire brc_pkg::mid_t  in_item,
  output logic                out_vld,
  output logic [15:0]         temp,
  output logic [19:0]         pres,
  output logic                fault
);
  typedef struct packed {
    logic [31:0] b6;
    logic [31:0] b5;
    logic [15:0] up;
    logic        fault;
  } a_t;
  typedef struct packed {
    logic [15:0] t;
    logic        split;
    logic        fault;
  } dtag_t;

  // stage 1: b6, b6*b6, ac2*b6, ac3*b6
  logic a_vld, b_vld, c_vld, e_vld, f_vld, g_vld, h_vld;
  a_t   a;
  logic [31:0] a_sq0, a_p2, a_p3;
  // stage 2
  a_t   b;
  logic [31:0] b_p2, b_p3, b_sq;
  logic [31:0] b_m1, b_m2;
  // stage 3
  a_t   c;
  logic [31:0] c_b3, c_x3;
  // stage 4
  a_t   e;
  logic [31:0] e_b3, e_b4;
  // stage 5
  logic [31:0] f_b7, f_b4;
  logic [15:0] f_t;
  logic        f_fault;
  logic [15:0] tsat;
  logic [31:0] b5t;
  // divider
  logic [31:0] dnum;
  logic        dv;
  logic [31:0] dq;
  dtag_t       dtin, dt;
  logic [brc_pkg::DivTagW-1:0] dtag_in, dtag_out;
  logic [31:0] p;
  logic [31:0] g_p;
  logic [15:0] g_t;
  logic        g_fault;
  logic [31:0] h_p, h_x1, h_x2;
  logic [15:0] h_t;
  logic        h_fault;
  logic [31:0] pf;
  logic [31:0] g_p8;

  always_comb begin
    b5t = in_item.b5 + 32'd8;
    b5t = brc_pkg::asr(b5t, 4);
    if ($signed(b5t) > 32'sd32767) tsat = 16'h7fff;
    else if ($signed(b5t) < -32'sd32768) tsat = 16'h8000;
    else tsat = b5t[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0; b_vld <= 1'b0; c_vld <= 1'b0; e_vld <= 1'b0;
      f_vld <= 1'b0; g_vld <= 1'b0; h_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld; b_vld <= a_vld; c_vld <= b_vld; e_vld <= c_vld;
      f_vld <= e_vld; g_vld <= dv; h_vld <= g_vld;
    end
    if (en) begin
      a     <= '{b6: in_item.b5 - 32'd4000, b5: {16'd0, tsat},
               up: in_item.up, fault: in_item.fault};
      a_sq0 <= 32'((in_item.b5 - 32'd4000) * (in_item.b5 - 32'd4000));
      a_p2  <= 32'(brc_pkg::sext16(coef.ac2) * (in_item.b5 - 32'd4000));
      a_p3  <= 32'(brc_pkg::sext16(coef.ac3) * (in_item.b5 - 32'd4000));
      b     <= a;
      b_sq  <= brc_pkg::asr(a_sq0, 12);
      b_p2  <= a_p2;
      b_p3  <= a_p3;
      c     <= b;
      c_x3  <= brc_pkg::asr(b_m1, 11) + brc_pkg::asr(b_p2, 11);
      c_b3  <= brc_pkg::asr(b_p3, 13) + brc_pkg::asr(b_m2, 16);
      e     <= c;
      e_b3  <= 32'($signed({{14{coef.ac1[15]}}, coef.ac1, 2'b00} + c_x3 + 32'd2)
                  / 32'sd4);
      e_b4  <= 32'(coef.ac4 * (brc_pkg::asr(c_b3 + 32'd2, 2) + 32'd32768)) >> 15;
      f_b7  <= 32'(({16'd0, e.up} - e_b3) * 32'd50000);
      f_b4  <= e_b4;
      f_t   <= e.b5[15:0];
      f_fault <= e.fault || (e_b4 == '0);
      g_p   <= p;
      g_p8  <= 32'(brc_pkg::asr(p, 8) * brc_pkg::asr(p, 8));
      g_t   <= dt.t;
      g_fault <= dt.fault;
      h_p   <= g_p;
      h_x1  <= brc_pkg::asr(32'(g_p8 * 32'd3038), 16);
      h_x2  <= brc_pkg::asr(32'((32'd0 - 32'd7357) * g_p), 16);
      h_t   <= g_t;
      h_fault <= g_fault;
    end
  end

  assign b_m1 = 32'(brc_pkg::sext16(coef.b1b2[15:0]) * b_sq);
  assign b_m2 = 32'(brc_pkg::sext16(coef.b1b2[31:16]) * b_sq);

  assign dnum = f_b7[31] ? f_b7 : {f_b7[30:0], 1'b0};
  assign dtin = '{t: f_t, split: f_b7[31], fault: f_fault};
  assign dtag_in = {{(brc_pkg::DivTagW - $bits(dtag_t)){1'b0}}, dtin};
  brc_div u_div (
    .clk, .rst, .en,
    .in_vld (f_vld),
    .in_num (dnum),
    .in_den (f_b4),
    .in_tag (dtag_in),
    .out_vld(dv),
    .out_quo(dq),
    .out_tag(dtag_out)
  );
  assign dt = dtag_t'(dtag_out[$bits(dtag_t)-1:0]);
  assign p = dt.split ? {dq[30:0], 1'b0} : dq;

  always_comb begin
    pf = h_p + brc_pkg::asr(h_x1 + h_x2 + 32'd3791, 4);
    out_vld = h_vld;
    fault = h_fault;
    temp = h_fault ? 16'd0 : h_t;
    if (h_fault || pf[31]) pres = '0;
    else if (pf[31:20] != '0) pres = 20'hfffff;
    else pres = pf[19:0];
  end
endmodule
`default_nettype wire

FILE: src/barometer_reading_compensation.sv
// Top level of the barometric reading compensator.
// Throughput: one reading per cycle unless stalled; every stage, both 32-stage dividers included, is pipelined.
// The front and back halves stall independently; a four-entry queue parts them.
// Reset (rst, synchronous) clears all coefficients to zero and empties every stage.
`default_nettype none
module barometer_reading_compensation (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] raw_temperature,
  input  wire logic [15:0] raw_pressure,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      temperature_tenths,
  output logic [19:0]      pressure_pa,
  output logic             divide_fault
);
  brc_pkg::coef_t coef;
  brc_pkg::mid_t  f_item, q_item;
  logic           f_vld, q_ne, b_vld, fen, ben;
  logic [brc_pkg::QueuePtrW:0] q_cnt;
  logic [15:0] b_t;
  logic [19:0] b_p;
  logic        b_f;
  logic        ovld;

  // Coefficient registers; configuration is always taken.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_valid) begin
      unique case (brc_pkg::reg_idx_t'(cfg_index))
        brc_pkg::REG_AC1:  coef.ac1  <= cfg_data[15:0];
        brc_pkg::REG_AC2:  coef.ac2  <= cfg_data[15:0];
        brc_pkg::REG_AC3:  coef.ac3  <= cfg_data[15:0];
        brc_pkg::REG_AC4:  coef.ac4  <= cfg_data[15:0];
        brc_pkg::REG_AC5:  coef.ac5  <= cfg_data[15:0];
        brc_pkg::REG_AC6:  coef.ac6  <= cfg_data[15:0];
        brc_pkg::REG_B1B2: coef.b1b2 <= cfg_data;
        brc_pkg::REG_MCMD: coef.mcmd <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front pipeline freezes as a whole only when the queue is full and it has
  // an item to hand over, so a new reading can be taken whenever it advances.
  assign fen = 1'b1 && (q_cnt < 3'(brc_pkg::QueueDepth)) || !f_vld;
  assign in_ready = fen;

  brc_front u_front (
    .clk, .rst, .en(fen), .coef,
    .in_vld(in_valid && in_ready),
    .ut(raw_temperature), .up(raw_pressure),
    .out_vld(f_vld), .out_item(f_item)
  );

  brc_queue u_q (
    .clk, .rst, .wr(f_vld && fen), .wdata(f_item),
    .rd(q_ne && ben), .nonempty(q_ne), .count(q_cnt), .rdata(q_item)
  );

  // Back pipeline advances whenever the output register is free or drained.
  assign ben = !ovld || out_ready;
  brc_back u_back (
    .clk, .rst, .en(ben), .coef,
    .in_vld(q_ne), .in_item(q_item),
    .out_vld(b_vld), .temp(b_t), .pres(b_p), .fault(b_f)
  );

  always_ff @(posedge clk) begin
    if (rst) ovld <= 1'b0;
    else if (ben) ovld <= b_vld;
    if (ben) begin
      temperature_tenths <= b_t;
      pressure_pa <= b_p;
      divide_fault <= b_f;
    end
  end
  assign out_valid = ovld;
endmodule
`default_nettype wire

FILE: src/brc_checker.sv
// Port-level checker for the compensator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module brc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] temperature_tenths,
  input wire logic [19:0] pressure_pa,
  input wire logic        divide_fault
);
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `CHK_NEXT(a_stable, clk, rst, out_valid && !out_ready, $stable(pressure_pa), "payload moved")
  `CHK_IMPLY(a_fault_p, clk, rst, out_valid && divide_fault, pressure_pa == '0, "fault pressure")
  `CHK_IMPLY(a_fault_t, clk, rst, out_valid && divide_fault, temperature_tenths == '0, "fault temp")
endmodule
bind barometer_reading_compensation brc_checker u_chk (.*);
`default_nettype wire
